>>> rtl/gds_pkg.sv
// gds_pkg: shared constants, types and register codes for the 2x2 box downscaler
// no dependencies; imported by every module of the block except gds_ram

package gds_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int LINE_DEPTH  = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W       = $clog2(LINE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int DIM_W       = 13;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = PIX_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] DIM_ONE      = DIM_W'(1);

    // rounding bias for the four-pixel mean
    localparam logic [SUM_W+1:0] ROUND_BIAS = (SUM_W + 2)'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // one block command from the front to the back
    typedef struct packed {
        logic             wr;        // store pair sum in line, no result
        logic             use_line;  // add stored pair sum of row above
        logic [SUM_W-1:0] sum;       // horizontal pair sum of this row
        logic [IDX_W-1:0] idx;       // line store entry
        logic             row_end;
        logic             frame_end;
    } cmd_t;

    // clamp a size register into 1..max
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_ONE;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

>>> rtl/gds_ram.sv
// gds_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module gds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gds_front.sv
// gds_front: accepts pixels, keeps size registers and raster counters,
// classifies each pixel and issues block commands; uses gds_pkg

module gds_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gds_pkg::PIX_W-1:0]    s_pixel_in,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gds_pkg::DIM_W-1:0]    cfg_data,
    input  logic                         q_full,
    output logic                         q_push,
    output gds_pkg::cmd_t                q_cmd
);
    import gds_pkg::*;

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] left_reg, left_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic             last_col, last_row, odd_col, odd_row, accept;
    logic [SUM_W-1:0] sum;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    assign w_eff    = clamp_dim(width_reg, WIDTH_MAX);
    assign h_eff    = clamp_dim(height_reg, HEIGHT_MAX);
    assign last_col = ({1'b0, col_reg} + DIM_ONE) >= w_eff;
    assign last_row = ({1'b0, row_reg} + DIM_ONE) >= h_eff;
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    // lone last pixel of an odd width counts doubled
    assign sum = odd_col ? ({1'b0, left_reg} + {1'b0, s_pixel_in}) : {s_pixel_in, 1'b0};

    always_comb begin
        q_cmd.wr        = !odd_row && !last_row;
        q_cmd.use_line  = odd_row;
        q_cmd.sum       = sum;
        q_cmd.idx       = col_reg[CNT_W-1:1];
        q_cmd.row_end   = last_col;
        q_cmd.frame_end = last_col && last_row;
        q_push          = accept && (odd_col || last_col);
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
        if (accept) begin
            if (!odd_col && !last_col) begin
                left_next = s_pixel_in;
            end
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CNT_W'(1);
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
        end
    end

endmodule

>>> rtl/gds_queue.sv
// gds_queue: short command fifo between front and back
// uses gds_pkg for cmd_t and depth constants

module gds_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gds_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output gds_pkg::cmd_t head_cmd
);
    import gds_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("command popped from empty queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue fill count lost a push");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

>>> rtl/gds_back.sv
// gds_back: executes block commands against the pair-sum line store,
// forms the rounded mean and holds the result word; uses gds_pkg, gds_ram

module gds_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  gds_pkg::cmd_t             q_cmd,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [gds_pkg::PIX_W-1:0] m_pixel_out,
    output logic                      m_row_end,
    output logic                      m_frame_end
);
    import gds_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    cmd_t             s1_cmd_reg;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_row_end_reg, out_frame_end_reg;

    logic             s1_adv, ram_we, ram_re;
    logic [SUM_W-1:0] line_sum;
    logic [SUM_W+1:0] total;
    logic [PIX_W-1:0] avg;

    // result stage advances when the output word is free or being taken
    assign s1_adv = s1_valid_reg && (!out_valid_reg || m_ready);
    // line writes never occupy the result stage
    assign q_pop  = q_valid && (q_cmd.wr || !s1_valid_reg || s1_adv);
    assign ram_we = q_pop && q_cmd.wr;
    assign ram_re = q_pop && !q_cmd.wr && q_cmd.use_line;

    gds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_cmd.idx),
        .wdata (q_cmd.sum),
        .re    (ram_re),
        .raddr (q_cmd.idx),
        .rdata (line_sum)
    );

    always_comb begin
        if (s1_cmd_reg.use_line) begin
            total = {2'b00, line_sum} + {2'b00, s1_cmd_reg.sum} + ROUND_BIAS;
        end else begin
            total = {1'b0, s1_cmd_reg.sum, 1'b0} + ROUND_BIAS;
        end
        // two pair sums of at most 510 plus bias stay below 1024
        avg = total[PIX_W+1:2];
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (q_pop && !q_cmd.wr) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !q_cmd.wr) begin
            s1_cmd_reg <= q_cmd;
        end
        if (s1_adv) begin
            out_pix_reg       <= avg;
            out_row_end_reg   <= s1_cmd_reg.row_end;
            out_frame_end_reg <= s1_cmd_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pix_reg;
    assign m_row_end   = out_row_end_reg;
    assign m_frame_end = out_frame_end_reg;

endmodule

>>> rtl/gray_downscale_2x2_box_top.sv
// gray_downscale_2x2_box_top: top level of the 2x2 box downscaler
// uses gds_pkg, gds_front, gds_queue, gds_back (which holds gds_ram)
//
// usage
// - s_ channel: one 8-bit gray pixel word per handshake, raster order
// - m_ channel: one downscaled pixel word per 2x2 source block, with
//   m_row_end on the last word of an output row and m_frame_end on the
//   last word of the frame
// - cfg channel: cfg_index 0 writes image_width, 1 writes image_height
//   (13 bits, 1..4096, reset 640x480); write only while the block is idle
// - throughput: one pixel per clock sustained while the receiver takes results;
//   the front takes a word every cycle while the command queue has room, the
//   back retires one command per cycle while the result register is free
// - result path: a pixel that completes a block is written to a queue entry
//   on the accepting edge, then passes the line read and then the result
//   register before its word is on m_valid
// - pixels on even rows only store their pair sum in the line; results come
//   on odd rows, and on the last row of an odd-height image
// - receiver stall: the result register holds, the back stops, the 4-deep
//   command queue fills and then s_ready drops; nothing is lost
// - reset (aresetn low, synchronous): counters, queue and valids clear, size
//   registers go to 640x480; the line store is not cleared, no clearing pass

module gray_downscale_2x2_box_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gds_pkg::PIX_W-1:0]      s_pixel_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gds_pkg::PIX_W-1:0]      m_pixel_out,
    output logic                           m_row_end,
    output logic                           m_frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gds_pkg::DIM_W-1:0]      cfg_data
);
    import gds_pkg::*;

    // front to queue
    logic q_push, q_full;
    cmd_t push_cmd;
    // queue to back
    logic q_pop, q_not_empty;
    cmd_t head_cmd;

    // counters, size registers, pixel classification
    gds_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_in (s_pixel_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // decouples the pixel side from output stalls
    gds_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // line store access, averaging, result register
    gds_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end)
    );

endmodule

>>> test/gray_downscale_2x2_box_top_tb.sv
// gray_downscale_2x2_box_top_tb: self-checking testbench for the 2x2 box downscaler
// depends on gds_pkg and gray_downscale_2x2_box_top; holds its own pixel predictor
// and compares every result word, field by field, against it

module gray_downscale_2x2_box_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gds_pkg::*;

    localparam int CLK_PERIOD    = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 8;        // slack after the last expected word
    localparam int CYCLE_LIMIT   = 600_000;  // timeout guard
    localparam int RANDOM_ITEMS  = 660;
    localparam int WIDE_COLS     = 128;      // pixels sent under an oversize width
    localparam int TALL_ROWS     = 64;       // rows sent under an oversize height

    // register slots past the two size registers, never decoded
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    // one downscaled pixel word as it should leave the block
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } scaled_px_t;

    // clock, reset and block inputs, all known from time zero
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_in  = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [PIX_W-1:0]     m_pixel_out;
    logic                 m_row_end;
    logic                 m_frame_end;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [DIM_W-1:0]     cfg_data    = '0;

    // predictor state, mirrors the block after reset
    logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
    logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
    logic [SUM_W-1:0] pair_sums [LINE_DEPTH];
    logic [PIX_W-1:0] left_px    = '0;
    logic [CNT_W-1:0] col_cnt    = '0;
    logic [CNT_W-1:0] row_cnt    = '0;

    scaled_px_t expected_px [$];
    scaled_px_t head_px;

    // idling odds in percent, changed per test phase
    int send_idle_pct  = 7;
    int recv_stall_pct = 49;

    int pixels_sent     = 0;
    int results_checked = 0;
    int frames_done     = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    gray_downscale_2x2_box_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // receiver stalls at random, never when the odds are zero
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // size register as the block uses it: zero means 1, oversize saturates
    function automatic logic [DIM_W-1:0] effective_size(input logic [DIM_W-1:0] v,
                                                        input int limit);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > limit) begin
            return DIM_W'(limit);
        end
        return v;
    endfunction

    // advance the predictor by one accepted source pixel
    function automatic void downscale_pixel(input logic [PIX_W-1:0] px);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] pair;
        logic [SUM_W+1:0] total;
        logic             last_col;
        logic             last_row;
        scaled_px_t       res;
        w        = effective_size(width_reg, MAX_WIDTH);
        h        = effective_size(height_reg, MAX_HEIGHT);
        last_col = (DIM_W'(col_cnt) + DIM_W'(1)) >= w;
        last_row = (DIM_W'(row_cnt) + DIM_W'(1)) >= h;
        idx      = col_cnt[CNT_W-1:1];
        if (col_cnt[0] || last_col) begin
            // a lone last pixel counts doubled
            pair = col_cnt[0] ? SUM_W'(left_px) + SUM_W'(px) : {px, 1'b0};
            if (row_cnt[0] || last_row) begin
                if (row_cnt[0]) begin
                    total = (SUM_W + 2)'(pair_sums[idx]) + (SUM_W + 2)'(pair) + ROUND_BIAS;
                end else begin
                    // last row of an odd height pairs with itself
                    total = (SUM_W + 2)'(pair) + (SUM_W + 2)'(pair) + ROUND_BIAS;
                end
                res.pixel     = total[PIX_W+1:2];
                res.row_end   = last_col;
                res.frame_end = last_col && last_row;
                expected_px.push_back(res);
            end else begin
                pair_sums[idx] = pair;
            end
        end else begin
            left_px = px;
        end
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + CNT_W'(1);
        end else begin
            col_cnt = col_cnt + CNT_W'(1);
        end
    endfunction

    // source pixels still needed to close the current frame
    function automatic int frame_pixels_left();
        int w;
        int h;
        int n;
        w = int'(effective_size(width_reg, MAX_WIDTH));
        h = int'(effective_size(height_reg, MAX_HEIGHT));
        n = (int'(col_cnt) + 1 >= w) ? 1 : w - int'(col_cnt);
        if (int'(row_cnt) + 1 < h) begin
            n += (h - int'(row_cnt) - 1) * w;
        end
        return n;
    endfunction

    // random pixel with extra weight on black and white
    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return PIX_W'($urandom_range(255));
            end
        endcase
    endfunction

    // result check, register tracking and prediction, all on the same edge
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d result words still expected", $time,
                     expected_px.size());
            $display("Mismatches found");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, actual %0d/%0b/%0b",
                             $time, m_pixel_out, m_row_end, m_frame_end);
                end else begin
                    head_px = expected_px.pop_front();
                    if (m_pixel_out !== head_px.pixel) begin
                        mismatches++;
                        $display("%0t: pixel_out expected %0d actual %0d", $time,
                                 head_px.pixel, m_pixel_out);
                    end
                    if (m_row_end !== head_px.row_end) begin
                        mismatches++;
                        $display("%0t: row_end expected %0b actual %0b", $time,
                                 head_px.row_end, m_row_end);
                    end
                    if (m_frame_end !== head_px.frame_end) begin
                        mismatches++;
                        $display("%0t: frame_end expected %0b actual %0b", $time,
                                 head_px.frame_end, m_frame_end);
                    end
                    results_checked++;
                    if (head_px.frame_end) begin
                        frames_done++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IMAGE_WIDTH) begin
                    width_reg = cfg_data;
                end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
                    height_reg = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                downscale_pixel(s_pixel_in);
            end
        end
    end

    // one pixel word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= px;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pixels_sent++;
    endtask

    // stop sending, wait for every expected word, then let the back settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_px.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= DIM_W'(value);
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // zero sizes, odd width and height, rounding and pixel extremes
    task automatic test_tiny_frames();
        logic [PIX_W-1:0] odd_frame [9] = '{8'd255, 8'd0, 8'd1,
                                            8'd0, 8'd255, 8'd2,
                                            8'd255, 8'd254, 8'd3};
        logic [PIX_W-1:0] tall_frame [8] = '{8'd255, 8'd255, 8'd255, 8'd255,
                                             8'd0, 8'd1, 8'd1, 8'd1};
        wait_drained();
        // zero in both registers acts as a 1x1 image
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        wait_drained();
        // 3x3: lone last column and a last row paired with itself
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        for (int i = 0; i < 9; i++) begin
            send_pixel(odd_frame[i]);
        end
        wait_drained();
        // 2x4: all-white block, then a block whose mean of 0.75 rounds up
        write_reg(CFG_IMAGE_WIDTH, 2);
        write_reg(CFG_IMAGE_HEIGHT, 4);
        for (int i = 0; i < 8; i++) begin
            send_pixel(tall_frame[i]);
        end
    endtask

    // oversize register values, each frame closed early by a smaller size
    task automatic test_size_extremes();
        int n;
        wait_drained();
        // oversize width saturates; a long even row fills the low line entries
        write_reg(CFG_IMAGE_WIDTH, 8191);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        repeat (WIDE_COLS) send_pixel(random_pixel());
        wait_drained();
        // still on the even row: one lone pixel ends it, the odd row follows
        write_reg(CFG_IMAGE_WIDTH, WIDE_COLS + 1);
        n = frame_pixels_left();
        repeat (n) send_pixel(random_pixel());
        wait_drained();
        // zero width, oversize height saturates
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 8191);
        repeat (TALL_ROWS) send_pixel(random_pixel());
        wait_drained();
        // odd height, last row paired with itself
        write_reg(CFG_IMAGE_HEIGHT, TALL_ROWS + 1);
        n = frame_pixels_left();
        repeat (n) send_pixel(random_pixel());
    endtask

    // sizes rewritten part way through a frame; counters keep running
    task automatic test_resize_mid_frame();
        int n;
        int k;
        wait_drained();
        // writes to undecoded slots must change nothing
        write_reg(CFG_SPARE_A, $urandom_range(8191));
        write_reg(CFG_SPARE_B, 8191);
        for (int r = 0; r < 16; r++) begin
            wait_drained();
            write_reg(CFG_IMAGE_WIDTH, $urandom_range(1, 12));
            write_reg(CFG_IMAGE_HEIGHT, $urandom_range(2, 6));
            n = frame_pixels_left();
            k = $urandom_range(1, n - 1);
            repeat (k) send_pixel(random_pixel());
            // sender holds off until every word so far has come back
            wait_drained();
            // width only changes on an even row, so the odd row below
            // never reads a line entry that this row did not write
            if (row_cnt[0] == 1'b0) begin
                write_reg(CFG_IMAGE_WIDTH, $urandom_range(1, 12));
            end
            if ($urandom_range(2) != 0) begin
                write_reg(CFG_IMAGE_HEIGHT, $urandom_range(1, 6));
            end
            n = frame_pixels_left();
            repeat (n) send_pixel(random_pixel());
        end
    endtask

    // whole frames of random size and content, three idling phases
    task automatic test_random_frames();
        int w;
        int h;
        int n;
        int pause_at;
        int stop_at;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 49;
                end
                1: begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 7;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            stop_at = pixels_sent + RANDOM_ITEMS / 3;
            while (pixels_sent < stop_at) begin
                wait_drained();
                // mostly small frames, now and then a wider one
                if ($urandom_range(7) == 0) begin
                    w = $urandom_range(17, 96);
                    h = $urandom_range(1, 4);
                end else begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 8);
                end
                write_reg(CFG_IMAGE_WIDTH, w);
                write_reg(CFG_IMAGE_HEIGHT, h);
                n = w * h;
                pause_at = ($urandom_range(5) == 0) ? int'($urandom_range(n - 1)) : n;
                for (int i = 0; i < n; i++) begin
                    if (i == pause_at) begin
                        wait_drained();
                    end
                    send_pixel(random_pixel());
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_tiny_frames();
        test_size_extremes();
        test_resize_mid_frame();
        test_random_frames();

        // end of stimulus: drain, then a few quiet cycles for stray words
        wait_drained();

        $display("run: %0d pixel words in, %0d result words checked, %0d frames closed",
                 pixels_sent, results_checked, frames_done);
        $display("run: 1x1 up to 129 wide and 65 tall, zero and oversize sizes, mid-frame resizes");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/gds_pkg.sv
rtl/gds_ram.sv
rtl/gds_front.sv
rtl/gds_queue.sv
rtl/gds_back.sv
rtl/gray_downscale_2x2_box_top.sv
test/gray_downscale_2x2_box_top_tb.sv
